### rtl/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// Widths, payload types and helpers shared by the face normal pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;

  // port and number formats
  localparam int DATA_W           = 32;  // width of every coordinate/normal port
  localparam int COORD_BITS       = 32;  // low bits of a coordinate port in use (<= DATA_W)
  localparam int NORMAL_FRAC_BITS = 30;  // fraction bits of a normal component

  // derived widths
  localparam int EW  = COORD_BITS + 1;          // edge component, signed
  localparam int PW  = 2 * EW;                  // edge product, signed
  localparam int CW  = PW + 1;                  // cross component, signed
  localparam int MW  = 2 * EW;                  // cross magnitude, unsigned
  localparam int HW  = EW;                      // half of a magnitude
  localparam int SQW = 2 * MW;                  // squared component
  localparam int SW  = SQW + 2;                 // sum of three squares
  localparam int RW  = SW + 2 * NORMAL_FRAC_BITS + 6;  // residual, two's complement
  localparam int QW  = NORMAL_FRAC_BITS + 1;    // rounded magnitude, up to 2^F

  // one triangle: v[vertex][axis]
  typedef struct packed {
    logic [2:0][2:0][DATA_W-1:0] v;
  } tri_t;

  // cross product as magnitude and sign
  typedef struct packed {
    logic [2:0][MW-1:0] mag;
    logic [2:0]         neg;
    logic               zero;
  } cross_t;

  // state of the per-bit rounding recurrence
  typedef struct packed {
    logic [2:0][RW-1:0] r;   // 4c^2 2^2F - (2q-1)^2 S
    logic [2:0][RW-1:0] t;   // (2q-1) S
    logic [SW-1:0]      s;   // |n|^2
    logic [2:0][QW-1:0] q;
    logic [2:0]         neg;
    logic               zero;
  } norm_t;

  // finished magnitudes
  typedef struct packed {
    logic [2:0][QW-1:0] q;
    logic [2:0]         neg;
    logic               zero;
  } unit_t;

  // sign-extend the used low bits of a coordinate port to edge width
  function automatic logic signed [EW-1:0] coord(input logic [DATA_W-1:0] x);
    return EW'($signed(x[COORD_BITS-1:0]));
  endfunction

endpackage

### rtl/tfn_cross.sv
// ----------------------------------------------------------------------------
// tfn_cross
// Edge vectors, edge products and cross product as sign and magnitude.
// Three register stages.
// ----------------------------------------------------------------------------
module tfn_cross import tfn_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  tri_t   tri_in,
  output logic   out_valid,
  input  logic   out_ready,
  output cross_t xprod
);

  logic v1, v2, v3;
  logic en1, en2, en3;
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  logic signed [PW-1:0] p0 [3];
  logic signed [PW-1:0] p1 [3];
  logic signed [CW-1:0] c  [3];
  cross_t cross_next;

  // stage advances when empty or when the next one moves
  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // stage 1: edges from vertex 0
  always_ff @(posedge clk) begin
    if (en1) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= coord(tri_in.v[1][i]) - coord(tri_in.v[0][i]);
        e2[i] <= coord(tri_in.v[2][i]) - coord(tri_in.v[0][i]);
      end
    end
  end

  // stage 2: six products
  always_ff @(posedge clk) begin
    if (en2) begin
      p0[0] <= e1[1] * e2[2];
      p1[0] <= e1[2] * e2[1];
      p0[1] <= e1[2] * e2[0];
      p1[1] <= e1[0] * e2[2];
      p0[2] <= e1[0] * e2[1];
      p1[2] <= e1[1] * e2[0];
    end
  end

  // stage 3: differences, split into sign and magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c[i]                = CW'(p0[i]) - CW'(p1[i]);
      cross_next.neg[i]   = c[i][CW-1];
      cross_next.mag[i]   = c[i][CW-1] ? MW'(-c[i]) : MW'(c[i]);
    end
    cross_next.zero = (c[0] == '0) && (c[1] == '0) && (c[2] == '0);
  end

  always_ff @(posedge clk) begin
    if (en3) xprod <= cross_next;
  end

  assign out_valid = v3;

endmodule

### rtl/tfn_square.sv
// ----------------------------------------------------------------------------
// tfn_square
// Squares of the cross components, their sum and the starting residuals
// of the rounding recurrence. Four register stages.
// ----------------------------------------------------------------------------
module tfn_square import tfn_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  cross_t xprod,
  output logic   out_valid,
  input  logic   out_ready,
  output norm_t  norm
);

  logic v4, v5, v6, v7;
  logic en4, en5, en6, en7;
  logic [2*HW-1:0] hh [3];
  logic [2*HW-1:0] hl [3];
  logic [2*HW-1:0] ll [3];
  logic [2:0]      neg4, neg5, neg6;
  logic            zero4, zero5, zero6;
  logic [SQW-1:0]  sq5 [3];
  logic [SQW-1:0]  sq6 [3];
  logic [SW-1:0]   s6;

  assign en7      = !v7 || out_ready;
  assign en6      = !v6 || en7;
  assign en5      = !v5 || en6;
  assign en4      = !v4 || en5;
  assign in_ready = en4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (en4) v4 <= in_valid;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
      if (en7) v7 <= v6;
    end
  end

  // stage 4: half-width partial products
  always_ff @(posedge clk) begin
    if (en4) begin
      for (int i = 0; i < 3; i++) begin
        hh[i] <= xprod.mag[i][MW-1:HW] * xprod.mag[i][MW-1:HW];
        hl[i] <= xprod.mag[i][MW-1:HW] * xprod.mag[i][HW-1:0];
        ll[i] <= xprod.mag[i][HW-1:0]  * xprod.mag[i][HW-1:0];
      end
      neg4  <= xprod.neg;
      zero4 <= xprod.zero;
    end
  end

  // stage 5: assemble each square
  always_ff @(posedge clk) begin
    if (en5) begin
      for (int i = 0; i < 3; i++) begin
        sq5[i] <= (SQW'(hh[i]) << (2 * HW)) + (SQW'(hl[i]) << (HW + 1)) + SQW'(ll[i]);
      end
      neg5  <= neg4;
      zero5 <= zero4;
    end
  end

  // stage 6: squared length
  always_ff @(posedge clk) begin
    if (en6) begin
      s6    <= SW'(sq5[0]) + SW'(sq5[1]) + SW'(sq5[2]);
      sq6   <= sq5;
      neg6  <= neg5;
      zero6 <= zero5;
    end
  end

  // stage 7: start with q = 0, i.e. d = 2q-1 = -1
  always_ff @(posedge clk) begin
    if (en7) begin
      for (int i = 0; i < 3; i++) begin
        norm.r[i] <= (RW'(sq6[i]) << (2 * NORMAL_FRAC_BITS + 2)) - RW'(s6);
        norm.t[i] <= RW'(0) - RW'(s6);
        norm.q[i] <= '0;
      end
      norm.s    <= s6;
      norm.neg  <= neg6;
      norm.zero <= zero6;
    end
  end

  assign out_valid = v7;

endmodule

### rtl/tfn_norm.sv
// ----------------------------------------------------------------------------
// tfn_norm
// Rounded unit-length magnitudes, one result bit per register stage,
// most significant first. Shift-and-add recurrence, no divider or root.
// ----------------------------------------------------------------------------
module tfn_norm import tfn_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  norm_t norm,
  output logic  out_valid,
  input  logic  out_ready,
  output unit_t unit
);

  logic  v  [QW];
  norm_t st [QW];
  wire [QW:0] en;

  assign en[QW]   = out_ready;
  assign in_ready = en[0];

  for (genvar j = 0; j < QW; j++) begin : g_bit
    localparam int K = NORMAL_FRAC_BITS - j;

    logic               src_v;
    norm_t              src;
    norm_t              nxt;
    logic [RW-1:0]      cand [3];

    if (j == 0) begin : g_first
      assign src_v = in_valid;
      assign src   = norm;
    end else begin : g_rest
      assign src_v = v[j-1];
      assign src   = st[j-1];
    end

    assign en[j] = !v[j] || en[j+1];

    // try setting bit K: (d + 2^(K+1))^2 S = d^2 S + 2^(K+2) dS + 2^(2K+2) S
    always_comb begin
      nxt = src;
      for (int i = 0; i < 3; i++) begin
        cand[i] = src.r[i] - (src.t[i] << (K + 2)) - (RW'(src.s) << (2 * K + 2));
        if (!cand[i][RW-1]) begin
          nxt.r[i] = cand[i];
          nxt.t[i] = src.t[i] + (RW'(src.s) << (K + 1));
          nxt.q[i] = src.q[i] | (QW'(1) << K);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (en[j]) begin
        v[j] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) st[j] <= nxt;
    end
  end

  assign out_valid = v[QW-1];
  assign unit.q    = st[QW-1].q;
  assign unit.neg  = st[QW-1].neg;
  assign unit.zero = st[QW-1].zero;

endmodule

### rtl/triangle_face_normal_unit.sv
// ----------------------------------------------------------------------------
// triangle_face_normal_unit
// Unit face normal of a triangle, exactly rounded Q2.30 components.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel tri_valid/tri_ready carries one triangle per request:
//   vertices (ax,ay,az), (bx,by,bz), (cx,cy,cz), signed Q16.16.
//   Output channel norm_valid/norm_ready returns one request per triangle:
//   nx, ny, nz (signed Q2.30, rounded to nearest, ties away from zero) and
//   degenerate, set with a zero vector when the cross product is zero.
//   Results leave in the order the triangles came in.
// Throughput: one triangle per cycle while norm_ready is high. Path from
//   acceptance to norm_valid: 3 stages edge/cross, 4 stages squares and length,
//   31 stages of the rounding recurrence (one result bit each) and the
//   output register.
// Stalls: each stage holds its request while the next is full, so a
//   stalled receiver fills the pipeline; bubbles are squeezed out and
//   tri_ready stays high until every stage holds a request.
// Reset: rst (synchronous) empties the pipeline; no request in flight
//   survives it.
// ----------------------------------------------------------------------------
module triangle_face_normal_unit import tfn_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              tri_valid,
  output logic              tri_ready,
  input  logic [DATA_W-1:0] ax,
  input  logic [DATA_W-1:0] ay,
  input  logic [DATA_W-1:0] az,
  input  logic [DATA_W-1:0] bx,
  input  logic [DATA_W-1:0] by,
  input  logic [DATA_W-1:0] bz,
  input  logic [DATA_W-1:0] cx,
  input  logic [DATA_W-1:0] cy,
  input  logic [DATA_W-1:0] cz,
  output logic              norm_valid,
  input  logic              norm_ready,
  output logic [DATA_W-1:0] nx,
  output logic [DATA_W-1:0] ny,
  output logic [DATA_W-1:0] nz,
  output logic              degenerate
);

  tri_t   tri_in;
  cross_t xprod;
  norm_t  norm;
  unit_t  unit;
  logic   cross_valid, cross_ready;
  logic   sq_valid, sq_ready;
  logic   unit_valid, unit_ready;
  logic   [DATA_W-1:0] comp [3];

  // pack the vertices
  assign tri_in.v[0][0] = ax;
  assign tri_in.v[0][1] = ay;
  assign tri_in.v[0][2] = az;
  assign tri_in.v[1][0] = bx;
  assign tri_in.v[1][1] = by;
  assign tri_in.v[1][2] = bz;
  assign tri_in.v[2][0] = cx;
  assign tri_in.v[2][1] = cy;
  assign tri_in.v[2][2] = cz;

  tfn_cross u_cross (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tri_valid),
    .in_ready  (tri_ready),
    .tri_in    (tri_in),
    .out_valid (cross_valid),
    .out_ready (cross_ready),
    .xprod     (xprod)
  );

  tfn_square u_square (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cross_valid),
    .in_ready  (cross_ready),
    .xprod     (xprod),
    .out_valid (sq_valid),
    .out_ready (sq_ready),
    .norm      (norm)
  );

  tfn_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .in_ready  (sq_ready),
    .norm      (norm),
    .out_valid (unit_valid),
    .out_ready (unit_ready),
    .unit      (unit)
  );

  // signed components; a degenerate triangle gives a zero vector
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (unit.zero) begin
        comp[i] = '0;
      end else if (unit.neg[i]) begin
        comp[i] = DATA_W'(0) - DATA_W'(unit.q[i]);
      end else begin
        comp[i] = DATA_W'(unit.q[i]);
      end
    end
  end

  // output register
  assign unit_ready = !norm_valid || norm_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      norm_valid <= 1'b0;
    end else if (unit_ready) begin
      norm_valid <= unit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (unit_ready) begin
      nx         <= comp[0];
      ny         <= comp[1];
      nz         <= comp[2];
      degenerate <= unit.zero;
    end
  end

endmodule

### sim/triangle_face_normal_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_face_normal_unit_test
// Streams triangles through the face normal unit and checks every returned
// normal against an exact wide-integer computation of the rounded unit
// vector, under several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module triangle_face_normal_unit_test;
  import tfn_pkg::*;

  localparam int LIMIT_CYCLES = 400000;

  // one triangle: ax, ay, az, bx, by, bz, cx, cy, cz
  typedef logic [8:0][DATA_W-1:0] triangle_t;

  typedef struct {
    logic [DATA_W-1:0] x, y, z;
    logic              deg;
  } normal_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              tri_valid = 1'b0;
  logic              tri_ready;
  triangle_t         tri_pay = '0;
  logic              norm_valid;
  logic              norm_ready = 1'b0;
  logic [DATA_W-1:0] nx, ny, nz;
  logic              degenerate;

  triangle_t pending_tris[$];
  normal_t   expected_normals[$];
  int        send_gap_pct = 0;
  int        recv_stall_pct = 0;
  logic      send_hold = 1'b0;
  logic      tri_taken = 1'b0;
  int        mismatches = 0;
  int        cycle_count = 0;

  triangle_face_normal_unit dut (
    .clk(clk), .rst(rst),
    .tri_valid(tri_valid), .tri_ready(tri_ready),
    .ax(tri_pay[0]), .ay(tri_pay[1]), .az(tri_pay[2]),
    .bx(tri_pay[3]), .by(tri_pay[4]), .bz(tri_pay[5]),
    .cx(tri_pay[6]), .cy(tri_pay[7]), .cz(tri_pay[8]),
    .norm_valid(norm_valid), .norm_ready(norm_ready),
    .nx(nx), .ny(ny), .nz(nz), .degenerate(degenerate)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // coordinate port to signed value, low COORD_BITS in use
  function automatic logic signed [63:0] coord_value(input logic [DATA_W-1:0] p);
    logic [63:0] w;
    w = {{(64 - DATA_W){1'b0}}, p} << (64 - COORD_BITS);
    return $signed(w) >>> (64 - COORD_BITS);
  endfunction

  // largest q in [0, 2^F] with (2q-1)^2 S <= 4 c^2 2^2F
  function automatic logic [63:0] rounded_mag(input logic [255:0] csq,
                                              input logic [255:0] sum_sq);
    logic [255:0] rhs, lhs, d;
    logic [63:0]  lo, hi, mid;
    rhs = csq << (2 * NORMAL_FRAC_BITS + 2);
    lo = 0;
    hi = 64'd1 << NORMAL_FRAC_BITS;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      d = 256'(2 * mid - 1);
      lhs = d * d * sum_sq;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // exact unit face normal of one triangle
  function automatic normal_t face_normal(input triangle_t t);
    logic signed [63:0]  e1[3], e2[3];
    logic signed [127:0] cr[3];
    logic [255:0]        sq[3], sum_sq;
    logic [63:0]         q;
    logic [DATA_W-1:0]   comp[3];
    normal_t             n;
    for (int i = 0; i < 3; i++) begin
      e1[i] = coord_value(t[3 + i]) - coord_value(t[i]);
      e2[i] = coord_value(t[6 + i]) - coord_value(t[i]);
    end
    cr[0] = 128'(e1[1]) * 128'(e2[2]) - 128'(e1[2]) * 128'(e2[1]);
    cr[1] = 128'(e1[2]) * 128'(e2[0]) - 128'(e1[0]) * 128'(e2[2]);
    cr[2] = 128'(e1[0]) * 128'(e2[1]) - 128'(e1[1]) * 128'(e2[0]);
    sum_sq = '0;
    for (int i = 0; i < 3; i++) begin
      sq[i] = 256'(cr[i] < 0 ? -cr[i] : cr[i]);
      sq[i] = sq[i] * sq[i];
      sum_sq = sum_sq + sq[i];
    end
    n.deg = (sum_sq == 0);
    for (int i = 0; i < 3; i++) begin
      q = n.deg ? 64'd0 : rounded_mag(sq[i], sum_sq);
      comp[i] = cr[i] < 0 ? DATA_W'(-q) : DATA_W'(q);
    end
    n.x = comp[0];
    n.y = comp[1];
    n.z = comp[2];
    return n;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    mismatches++;
    $display("t=%0t %s got %h want %h", $realtime, what, got, want);
  endtask

  // driver: new request at the falling edge once the last one was taken
  always @(negedge clk) begin
    if (rst) begin
      tri_valid <= 1'b0;
    end else if (!tri_valid || tri_taken) begin
      if (pending_tris.size() > 0 && !send_hold &&
          $urandom_range(99) >= send_gap_pct) begin
        tri_pay <= pending_tris.pop_front();
        tri_valid <= 1'b1;
      end else begin
        tri_valid <= 1'b0;
      end
    end
    norm_ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: accept requests and check results at the rising edge
  always @(posedge clk) begin
    normal_t want;
    tri_taken <= tri_valid && tri_ready;
    if (!rst && tri_valid && tri_ready)
      expected_normals.push_back(face_normal(tri_pay));
    if (!rst && norm_valid && norm_ready) begin
      if (expected_normals.size() == 0) begin
        mismatches++;
        $display("t=%0t result with nothing expected", $realtime);
      end else begin
        want = expected_normals.pop_front();
        if (nx !== want.x) report_mismatch("nx", nx, want.x);
        if (ny !== want.y) report_mismatch("ny", ny, want.y);
        if (nz !== want.z) report_mismatch("nz", nz, want.z);
        if (degenerate !== want.deg)
          report_mismatch("degenerate", DATA_W'(degenerate), DATA_W'(want.deg));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [DATA_W-1:0] rand_word();
    return DATA_W'($urandom);
  endfunction

  // random triangle of one of several shapes
  function automatic triangle_t random_triangle();
    triangle_t t;
    int        k;
    int        shape;
    shape = $urandom_range(9);
    for (int i = 0; i < 9; i++) t[i] = rand_word();
    case (shape)
      0, 1, 2: begin
        // near-origin vertices, small edges
        for (int i = 0; i < 9; i++)
          t[i] = DATA_W'($signed($urandom_range(4000)) - 2000) << $urandom_range(16);
      end
      3, 4: begin
        // local triangle at a random origin
        for (int i = 3; i < 9; i++)
          t[i] = t[i % 3] + DATA_W'($signed($urandom_range(2000)) - 1000);
      end
      5: begin
        // collinear: c = a + k (b - a)
        k = $signed($urandom_range(6)) - 3;
        for (int i = 0; i < 3; i++) begin
          t[3 + i] = t[i] + DATA_W'($signed($urandom_range(200)) - 100);
          t[6 + i] = t[i] + DATA_W'(k) * (t[3 + i] - t[i]);
        end
      end
      6: begin
        // extreme corner values
        for (int i = 0; i < 9; i++)
          case ($urandom_range(3))
            0: t[i] = {1'b1, {(DATA_W - 1){1'b0}}};
            1: t[i] = {1'b0, {(DATA_W - 1){1'b1}}};
            2: t[i] = '0;
            default: t[i] = '1;
          endcase
      end
      default: ;
    endcase
    return t;
  endfunction

  task automatic wait_drained();
    while (pending_tris.size() > 0 || tri_valid || expected_normals.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    logic [DATA_W-1:0] mx, mn, one;
    int                gaps[4];
    int                stalls[4];
    mx = {1'b0, {(DATA_W - 1){1'b1}}};
    mn = {1'b1, {(DATA_W - 1){1'b0}}};
    one = DATA_W'(1) << 16;
    gaps = '{0, 52, 0, 15};
    stalls = '{0, 0, 52, 15};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: axis-aligned, extremes, degenerate cases
    pending_tris.push_back({9{32'd0}});
    pending_tris.push_back('{0, one, 0, one, 0, 0, 0, 0, 0});
    pending_tris.push_back('{0, 0, one, 0, one, 0, 0, 0, 0});
    pending_tris.push_back('{one, 0, 0, 0, 0, one, 0, 0, 0});
    pending_tris.push_back('{0, 0, one, one, 0, 0, 0, 0, 0});
    pending_tris.push_back('{mx, mx, mx, mx, mx, mx, mx, mx, mx});
    pending_tris.push_back('{mn, mn, mn, mn, mn, mn, mn, mn, mn});
    pending_tris.push_back('{mn, mn, mx, mn, mx, mn, mx, mn, mn});
    pending_tris.push_back('{mx, mx, mn, mx, mn, mx, mn, mx, mx});
    pending_tris.push_back('{mn, mx, mn, mx, mn, mx, mn, mn, mx});
    pending_tris.push_back('{0, 0, 0, mx, mx, mx, mn, mn, mn});
    pending_tris.push_back('{3, 2, 1, 2, 1, 0, 1, 0, -1});
    pending_tris.push_back('{0, 0, 1, 0, 1, 0, 1, 0, 0});
    pending_tris.push_back('{'1, '1, '1, 0, 0, 0, 1, 1, 1});
    pending_tris.push_back('{0, 0, 0, 1, 0, 0, 0, 1, 0});
    pending_tris.push_back('{0, 1, 2, 0, 1, 2, 0, 1, 2});
    pending_tris.push_back('{0, 0, 1, 0, 1, 0, 1, 1, 1});
    pending_tris.push_back('{mn, 0, 0, mx, 0, 0, 0, mx, 0});
    pending_tris.push_back('{0, mn, mx, mx, 0, mn, mn, mx, 0});
    pending_tris.push_back('{12, 5, 1, 0, 7, 3, 1, 1, 8});
    wait_drained();

    // random phases, each ending with a full drain
    for (int p = 0; p < 4; p++) begin
      send_gap_pct = gaps[p];
      recv_stall_pct = stalls[p];
      for (int i = 0; i < 140; i++) pending_tris.push_back(random_triangle());
      while (pending_tris.size() > 0) @(posedge clk);
      // hold the sender until the pipeline has emptied
      send_hold = 1'b1;
      wait_drained();
      send_hold = 1'b0;
      for (int i = 0; i < 140; i++) pending_tris.push_back(random_triangle());
      wait_drained();
    end

    recv_stall_pct = 0;
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
